/* rtl/spc_pkg.sv */
// Shared types, constants and lookup functions for the sine plasma cell shader.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package spc_pkg;

  // Screen geometry used by the fixed plasma centre
  localparam int ROWS = 25;
  localparam int COLS = 80;

  // Distance square root: radicand width, root width, low radicand bits dropped
  localparam int ROOT_SHIFT  = 2;
  localparam int ROOT_BITS   = 8;
  localparam int RAD_W       = 2 * ROOT_BITS;
  localparam int REM_W       = ROOT_BITS + 2;
  // difference, square, sum, then one stage per root bit
  localparam int DIST_STAGES = 3 + ROOT_BITS;
  localparam logic [RAD_W-1:0] ROOT_MASK = {RAD_W{1'b1}} << ROOT_SHIFT;

  typedef logic signed [8:0] coord_t;

  localparam coord_t FIX_CX      = 9'(ROWS);
  localparam coord_t FIX_CY      = 9'(COLS / 2);
  localparam coord_t ORBIT2_BASE = 9'sd60;
  localparam coord_t ORBIT3_BASE = 9'sd64;
  localparam logic [7:0] QUARTER_TURN = 8'd64;

  // Division by three: q = (m * 171) >> 9, exact for m <= 381
  localparam logic [7:0] RECIP3       = 8'd171;
  localparam int         RECIP3_SHIFT = 9;

  // Attribute and glyph codes
  localparam logic [15:0] ATTR_DIM    = 16'h0200;
  localparam logic [15:0] ATTR_BRIGHT = 16'h0A00;
  localparam logic [15:0] LOW_KEEP    = 16'h08FF;
  localparam logic [15:0] LOW_ATTR    = 16'h0100;
  localparam logic [15:0] CH_BLANK    = 16'h0020;
  localparam logic [15:0] CH_COLON    = 16'h003A;
  localparam logic [15:0] CH_SMALL_O  = 16'h006F;
  localparam logic [15:0] CH_BIG_O    = 16'h004F;
  localparam logic [15:0] CH_BIG_Q    = 16'h0051;

  localparam logic [15:0] GLYPH_WORDS [0:7] = '{
    CH_BLANK, CH_BLANK, ATTR_DIM | CH_COLON, ATTR_BRIGHT | CH_COLON,
    ATTR_DIM | CH_SMALL_O, ATTR_DIM | CH_BIG_O, ATTR_BRIGHT | CH_BIG_O,
    ATTR_BRIGHT | CH_BIG_Q
  };

  localparam logic [6:0] QUARTER_WAVE [0:64] = '{
    7'd0, 7'd3, 7'd6, 7'd9, 7'd12, 7'd15, 7'd18, 7'd21,
    7'd24, 7'd27, 7'd30, 7'd33, 7'd36, 7'd39, 7'd42, 7'd45,
    7'd48, 7'd51, 7'd54, 7'd57, 7'd59, 7'd62, 7'd65, 7'd67,
    7'd70, 7'd73, 7'd75, 7'd78, 7'd80, 7'd82, 7'd85, 7'd87,
    7'd89, 7'd91, 7'd94, 7'd96, 7'd98, 7'd100, 7'd102, 7'd103,
    7'd105, 7'd107, 7'd108, 7'd110, 7'd112, 7'd113, 7'd114, 7'd116,
    7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122, 7'd123, 7'd123,
    7'd124, 7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
    7'd127
  };

  typedef struct packed {
    logic [5:0]  cell_row;
    logic [6:0]  cell_col;
    logic [15:0] frame_time;
  } spc_in_t;

  typedef struct packed {
    logic [5:0]  cell_row_out;
    logic [6:0]  cell_col_out;
    logic [15:0] cell_word;
  } spc_out_t;

  // 256-entry signed sine, built from the quarter wave
  function automatic logic signed [7:0] sine_at(input logic [7:0] a);
    logic [6:0] ph;
    logic [6:0] q;
    logic [6:0] mag;
    ph  = a[6:0];
    q   = (ph <= 7'd64) ? ph : 7'(8'd128 - {1'b0, ph});
    mag = QUARTER_WAVE[q];
    if (a[7]) begin
      return 8'sd0 - signed'({1'b0, mag});
    end
    return signed'({1'b0, mag});
  endfunction

  // base + s/2, halving rounds toward zero
  function automatic coord_t centre(input logic signed [7:0] s, input coord_t base);
    logic signed [7:0] half;
    half = (s + signed'({7'd0, s[7]})) >>> 1;
    return base + {half[7], half};
  endfunction

endpackage

/* rtl/sine_plasma_cell_shader.sv */
// Top level of the sine plasma cell shader: 17-stage pipeline, three distance lanes.
// Depends on spc_pkg and spc_dist.
`timescale 1ns / 1ps
//
// Usage
//   in_*  : one request per cell (row, column, frame time), valid/ready.
//   out_* : the cell's character/attribute word with its row and column echoed.
//   Each request yields exactly one result, in request order.
//   Throughput: one cell per clock while out_ready is high; a result shows
//   on out_valid from the output register. The depth is set by the input
//   register and the orbit-centre stage, then the eight square-root stages
//   (one root bit each) plus difference, squaring and sum stages in each
//   distance lane, then sine, three-way sum, divide-by-three and glyph stages.
//   Every stage carries its own valid bit. When out_ready is low the result
//   holds in the output register, stalled stages keep their contents, and
//   empty stages further up still fill; in_ready falls only when all 17
//   stages hold a request.
//   Reset (rst_n low, synchronous) clears the valid bits; the sine and glyph
//   tables are constant logic and need no loading, so the block accepts
//   requests as soon as reset is released.

module sine_plasma_cell_shader (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  spc_pkg::spc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output spc_pkg::spc_out_t out_data
);
  import spc_pkg::*;

  localparam int S_CEN  = 1;
  localparam int S_DIST = 2;
  localparam int S_SINE = S_DIST + DIST_STAGES;
  localparam int S_SUM  = S_SINE + 1;
  localparam int S_MEAN = S_SUM + 1;
  localparam int S_OUT  = S_MEAN + 1;
  localparam int NS     = S_OUT + 1;

  logic [NS-1:0] valid_r, valid_nxt;
  logic [NS:0]   rdy;

  spc_in_t           item_r [0:S_OUT-1];
  coord_t            c2x_r, c2y_r, c3x_r, c3y_r;
  logic signed [7:0] v1_r, v2_r, v3_r;
  logic signed [9:0] sum_r;
  logic signed [7:0] mean_r;
  spc_out_t          out_r;

  // ---- handshake: each stage loads when it is empty or its successor moves
  assign rdy[NS] = out_ready;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !valid_r[k] || rdy[k+1];
  end

  always_comb begin
    valid_nxt[0] = rdy[0] ? in_valid : valid_r[0];
    for (int k = 1; k < NS; k++) begin
      valid_nxt[k] = rdy[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = valid_r[NS-1];
  assign out_data  = out_r;

  // ---- cell position and time travel alongside the work
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      item_r[0] <= in_data;
    end
    for (int k = 1; k < S_OUT; k++) begin
      if (rdy[k]) begin
        item_r[k] <= item_r[k-1];
      end
    end
  end

  // ---- orbiting centres
  logic [15:0] t0;
  logic [7:0]  ang_a, ang_b, t3;

  assign t0    = item_r[0].frame_time;
  assign ang_a = t0[12:5];
  assign t3    = {t0[6:0], 1'b0} + t0[7:0];
  assign ang_b = 8'd0 - t3;

  always_ff @(posedge clk) begin
    if (rdy[S_CEN]) begin
      c2x_r <= centre(sine_at(ang_a), ORBIT2_BASE);
      c2y_r <= centre(sine_at(QUARTER_TURN - ang_a), ORBIT2_BASE);
      c3x_r <= centre(sine_at(ang_b), ORBIT3_BASE);
      c3y_r <= centre(sine_at(QUARTER_TURN - ang_b), ORBIT3_BASE);
    end
  end

  // ---- three distance lanes
  coord_t                 px, py;
  logic [ROOT_BITS-1:0]   d1, d2, d3;
  logic [DIST_STAGES-1:0] dist_en;

  assign px      = signed'({2'b00, item_r[S_CEN].cell_row, 1'b0});
  assign py      = signed'({2'b00, item_r[S_CEN].cell_col});
  assign dist_en = rdy[S_SINE-1:S_DIST];

  spc_dist u_dist_fix (
    .clk(clk), .en(dist_en), .x(px), .y(py), .cx(FIX_CX), .cy(FIX_CY), .root_out(d1)
  );
  spc_dist u_dist_orb2 (
    .clk(clk), .en(dist_en), .x(px), .y(py), .cx(c2x_r), .cy(c2y_r), .root_out(d2)
  );
  spc_dist u_dist_orb3 (
    .clk(clk), .en(dist_en), .x(px), .y(py), .cx(c3x_r), .cy(c3y_r), .root_out(d3)
  );

  // ---- sines, sum, mean
  logic [15:0] t_s;
  logic [7:0]  arg1;
  logic [9:0]  mag;
  logic [16:0] prod;
  logic [7:0]  quot;

  assign t_s  = item_r[S_SINE-1].frame_time;
  assign arg1 = {d1[6:0], 1'b0} + {t_s[6:0], 1'b0};

  assign mag  = sum_r[9] ? 10'(-sum_r) : 10'(sum_r);
  assign prod = mag[8:0] * RECIP3;
  assign quot = prod[16:RECIP3_SHIFT];

  always_ff @(posedge clk) begin
    if (rdy[S_SINE]) begin
      v1_r <= sine_at(arg1);
      v2_r <= sine_at(d2);
      v3_r <= sine_at(d3);
    end
    if (rdy[S_SUM]) begin
      sum_r <= {{2{v1_r[7]}}, v1_r} + {{2{v2_r[7]}}, v2_r} + {{2{v3_r[7]}}, v3_r};
    end
    if (rdy[S_MEAN]) begin
      mean_r <= sum_r[9] ? 8'sd0 - signed'(quot) : signed'(quot);
    end
  end

  // ---- glyph pick; band = (mean + 128) >> 4
  logic [3:0]  band, dist_band;
  logic        low_band;
  logic [2:0]  gidx;
  logic [15:0] word;

  always_comb begin
    band      = {~mean_r[7], mean_r[6:4]};
    low_band  = (band <= 4'd8);
    dist_band = low_band ? 4'd8 - band : band - 4'd8;
    gidx      = dist_band[3] ? 3'd7 : dist_band[2:0];
    word      = GLYPH_WORDS[gidx];
    if (low_band) begin
      word = (word & LOW_KEEP) | LOW_ATTR;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_OUT]) begin
      out_r.cell_row_out <= item_r[S_MEAN].cell_row;
      out_r.cell_col_out <= item_r[S_MEAN].cell_col;
      out_r.cell_word    <= word;
    end
  end

  // ---- checks
  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !(&valid_r) |-> in_ready)
    else $error("in_ready low while the pipeline has an empty stage");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> valid_r[0])
    else $error("accepted request did not enter the first stage");

  a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[S_MEAN] && rdy[S_OUT] |=> out_valid)
    else $error("result lost on the way into the output register");

  a_stall_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[S_SINE] && !rdy[S_SINE+1] |=> valid_r[S_SINE])
    else $error("stalled stage dropped its request");

endmodule

/* rtl/spc_dist.sv */
// One distance lane: difference, squares, sum, then a bit-per-stage square root.
// Depends on spc_pkg; stage enables come from the top level's valid/ready chain.
`timescale 1ns / 1ps

module spc_dist (
  input  logic                                clk,
  input  logic [spc_pkg::DIST_STAGES-1:0]     en,
  input  spc_pkg::coord_t                     x,
  input  spc_pkg::coord_t                     y,
  input  spc_pkg::coord_t                     cx,
  input  spc_pkg::coord_t                     cy,
  output logic [spc_pkg::ROOT_BITS-1:0]       root_out
);
  import spc_pkg::*;

  coord_t             dx_r, dy_r;
  logic signed [17:0] dx_sq, dy_sq;
  logic [RAD_W-1:0]   dx2_r, dy2_r, rad0_r;

  logic [RAD_W-1:0]     rad_r  [0:ROOT_BITS-2];
  logic [REM_W-1:0]     rem_r  [0:ROOT_BITS-1];
  logic [ROOT_BITS-1:0] root_r [0:ROOT_BITS-1];

  assign dx_sq = dx_r * dx_r;
  assign dy_sq = dy_r * dy_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dx_r <= x - cx;
      dy_r <= y - cy;
    end
    if (en[1]) begin
      dx2_r <= dx_sq[RAD_W-1:0];
      dy2_r <= dy_sq[RAD_W-1:0];
    end
    if (en[2]) begin
      // sum wraps at 16 bits; ROOT_MASK drops the low radicand bits
      rad0_r <= (dx2_r + dy2_r) & ROOT_MASK;
    end
  end

  // Restoring square root, two radicand bits per stage, MSB first
  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_sq
    logic [RAD_W-1:0]     rad_in;
    logic [REM_W-1:0]     rem_in;
    logic [ROOT_BITS-1:0] root_in;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    logic                 take;

    if (j == 0) begin : g_first
      assign rad_in  = rad0_r;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    // remainder never exceeds 2*root, so its top two bits are zero here
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (en[3+j]) begin
        rem_r[j]  <= take ? rem_sh - trial : rem_sh;
        root_r[j] <= {root_in[ROOT_BITS-2:0], take};
      end
    end

    if (j < ROOT_BITS - 1) begin : g_rad
      always_ff @(posedge clk) begin
        if (en[3+j]) begin
          rad_r[j] <= rad_in << 2;
        end
      end
    end
  end

  assign root_out = root_r[ROOT_BITS-1];

endmodule
